// ----- design/csem_pkg.sv -----
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants for the counting semaphore table
// Sizes of the slot table and the waiter link store, field widths, operation
// codes, the command word passed from front to back, and link helpers.
// ----------------------------------------------------------------------------
package csem_pkg;

  // table sizes
  localparam int NUM_SEMS    = 16;
  localparam int NUM_PROCS   = 64;
  localparam int MAX_RESULTS = 64;

  // field widths fixed by the interface
  localparam int MODE_W  = 2;
  localparam int ID_W    = 8;
  localparam int PID_W   = 6;
  localparam int COUNT_W = 16;
  localparam int CID_W   = 4;

  // derived internal widths
  localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PROC_W = $clog2(NUM_PROCS);
  localparam int LINK_W = $clog2(NUM_PROCS + 1);
  localparam int CNT_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // link value that ends a waiter list (always >= NUM_PROCS)
  localparam logic [LINK_W-1:0] EMPTY_LINK = '1;

  // count limits
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

  // request modes
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGNAL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

  // classified operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_WAIT   = 3'd1;
  localparam logic [OP_W-1:0] OP_SIGNAL = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_ERROR  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [SEM_W-1:0]          slot;
    logic [PID_W-1:0]          pid;
    logic signed [COUNT_W-1:0] init;
  } cmd_t;

  // process id to link value
  function automatic logic [LINK_W-1:0] pid_to_link(input logic [PID_W-1:0] p);
    logic [LINK_W+PID_W-1:0] w;
    w = {{LINK_W{1'b0}}, p};
    return w[LINK_W-1:0];
  endfunction

  // link value to process id field
  function automatic logic [PID_W-1:0] link_to_pid(input logic [LINK_W-1:0] l);
    logic [LINK_W+PID_W-1:0] w;
    w = {{PID_W{1'b0}}, l};
    return w[PID_W-1:0];
  endfunction

  // a link names a real process
  function automatic logic link_live(input logic [LINK_W-1:0] l);
    return ({1'b0, l} < (LINK_W+1)'(NUM_PROCS));
  endfunction

  // link store address of a live link
  function automatic logic [PROC_W-1:0] link_addr(input logic [LINK_W-1:0] l);
    return l[PROC_W-1:0];
  endfunction

endpackage

// ----- design/csem_front.sv -----
// ----------------------------------------------------------------------------
// csem_front: request intake and classification
// Takes request transfers, range-checks id and pid, and registers a command
// word for the back end.
// ----------------------------------------------------------------------------
module csem_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [csem_pkg::MODE_W-1:0]   mode,
  input  logic [csem_pkg::ID_W-1:0]     sem_id,
  input  logic [csem_pkg::PID_W-1:0]    pid,
  input  logic signed [csem_pkg::COUNT_W-1:0] initial_count,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output csem_pkg::cmd_t                cmd
);
  import csem_pkg::*;

  logic id_ok;
  logic pid_ok;
  cmd_t cmd_next;

  // range checks and operation decode
  always_comb begin
    id_ok  = ({1'b0, sem_id} < (ID_W+1)'(NUM_SEMS));
    pid_ok = ({3'b000, pid} < (PID_W+3)'(NUM_PROCS));
    cmd_next.slot = sem_id[SEM_W-1:0];
    cmd_next.pid  = pid;
    cmd_next.init = initial_count;
    case (mode)
      MODE_CREATE: cmd_next.op = OP_CREATE;
      MODE_WAIT:   cmd_next.op = (id_ok && pid_ok) ? OP_WAIT : OP_ERROR;
      MODE_SIGNAL: cmd_next.op = id_ok ? OP_SIGNAL : OP_ERROR;
      MODE_DELETE: cmd_next.op = id_ok ? OP_DELETE : OP_ERROR;
      default:     cmd_next.op = OP_ERROR;
    endcase
  end

  assign req_ready = !cmd_valid || cmd_ready;

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_ready) begin
      cmd_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- design/csem_cmdq.sv -----
// ----------------------------------------------------------------------------
// csem_cmdq: short command queue
// Small FIFO of classified commands that lets the front keep taking requests
// while the back end is busy with a multi-cycle operation.
// ----------------------------------------------------------------------------
module csem_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  csem_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output csem_pkg::cmd_t pop_cmd
);
  import csem_pkg::*;

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != CMDQ_CW'(CMDQ_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = q[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- design/csem_back.sv -----
// ----------------------------------------------------------------------------
// csem_back: semaphore execution engine
// Holds the slot table and the waiter link store, carries out create, wait,
// signal and delete, and drives the registered response stage.
// ----------------------------------------------------------------------------
module csem_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  csem_pkg::cmd_t              cmd,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        status,
  output logic [csem_pkg::CID_W-1:0]  created_id,
  output logic                        must_block,
  output logic                        woken_valid,
  output logic [csem_pkg::PID_W-1:0]  woken_pid,
  output logic                        last
);
  import csem_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LINK = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_WALK = 2'd3;

  // slot table
  logic [NUM_SEMS-1:0]       used;
  logic signed [COUNT_W-1:0] level  [NUM_SEMS];
  logic [LINK_W-1:0]         qfirst [NUM_SEMS];
  logic [LINK_W-1:0]         qlast  [NUM_SEMS];

  // waiter link store
  logic [LINK_W-1:0] next_waiter [NUM_PROCS];
  logic [LINK_W-1:0] rdata;

  // sequencer and working registers
  logic [1:0]        state, state_next;
  logic [SEM_W-1:0]  wslot;
  logic [PID_W-1:0]  wpid;
  logic [LINK_W-1:0] cur, cur_next;
  logic [CNT_W-1:0]  kcnt, kcnt_next;
  logic              ld_work;

  // slot view
  logic [SEM_W-1:0]          sel_slot;
  logic signed [COUNT_W-1:0] lvl, lvl_dec, lvl_inc;
  logic [LINK_W-1:0]         sfirst, slast;
  logic                      sused;

  // free slot search
  logic             free_found;
  logic [SEM_W-1:0] free_idx;
  logic [SEM_W+CID_W-1:0] cid_ext;

  // table write controls
  logic [SEM_W-1:0]          tbl_idx;
  logic                      wr_used, used_val;
  logic                      wr_level;
  logic signed [COUNT_W-1:0] level_val;
  logic                      wr_first, wr_last;
  logic [LINK_W-1:0]         first_val, last_val;

  // link store controls
  logic              mw_en, mr_en;
  logic [PROC_W-1:0] mw_addr, mr_addr;
  logic [LINK_W-1:0] mw_data;

  // response controls
  logic             out_free;
  logic             emit;
  logic             e_status, e_blk, e_wv, e_last;
  logic [CID_W-1:0] e_cid;
  logic [PID_W-1:0] e_wp;

  assign out_free = !rsp_valid || rsp_ready;
  assign sel_slot = (state == ST_IDLE) ? cmd.slot : wslot;
  assign lvl      = level[sel_slot];
  assign sfirst   = qfirst[sel_slot];
  assign slast    = qlast[sel_slot];
  assign sused    = used[sel_slot];
  assign lvl_dec  = (lvl == COUNT_MIN) ? lvl : lvl - 16'sd1;
  assign lvl_inc  = (lvl == COUNT_MAX) ? lvl : lvl + 16'sd1;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SEM_W'(i);
      end
    end
  end

  assign cid_ext = {{CID_W{1'b0}}, free_idx};

  // operation sequencer
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    ld_work    = 1'b0;
    cur_next   = cur;
    kcnt_next  = kcnt;
    tbl_idx    = sel_slot;
    wr_used    = 1'b0;
    used_val   = 1'b0;
    wr_level   = 1'b0;
    level_val  = lvl;
    wr_first   = 1'b0;
    first_val  = EMPTY_LINK;
    wr_last    = 1'b0;
    last_val   = EMPTY_LINK;
    mw_en      = 1'b0;
    mw_addr    = '0;
    mw_data    = EMPTY_LINK;
    mr_en      = 1'b0;
    mr_addr    = '0;
    emit       = 1'b0;
    e_status   = 1'b0;
    e_cid      = '0;
    e_blk      = 1'b0;
    e_wv       = 1'b0;
    e_wp       = '0;
    e_last     = 1'b1;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          ld_work   = 1'b1;
          case (cmd.op)
            OP_CREATE: begin
              emit = 1'b1;
              if (free_found) begin
                tbl_idx   = free_idx;
                wr_used   = 1'b1;
                used_val  = 1'b1;
                wr_level  = 1'b1;
                level_val = cmd.init;
                wr_first  = 1'b1;
                wr_last   = 1'b1;
                e_cid     = cid_ext[CID_W-1:0];
              end else begin
                e_status = 1'b1;
              end
            end
            OP_WAIT: begin
              if (!sused) begin
                emit     = 1'b1;
                e_status = 1'b1;
              end else begin
                wr_level  = 1'b1;
                level_val = lvl_dec;
                if (lvl_dec[COUNT_W-1]) begin
                  // caller will queue: terminate its link first
                  mw_en      = 1'b1;
                  mw_addr    = link_addr(pid_to_link(cmd.pid));
                  mw_data    = EMPTY_LINK;
                  state_next = ST_LINK;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            OP_SIGNAL: begin
              if (!sused) begin
                emit     = 1'b1;
                e_status = 1'b1;
              end else begin
                wr_level  = 1'b1;
                level_val = lvl_inc;
                if (lvl_inc[COUNT_W-1] || (lvl_inc == '0)) begin
                  if (!link_live(sfirst)) begin
                    emit     = 1'b1;
                    e_status = 1'b1;
                  end else begin
                    mr_en      = 1'b1;
                    mr_addr    = link_addr(sfirst);
                    state_next = ST_POP;
                  end
                end else begin
                  emit = 1'b1;
                end
              end
            end
            OP_DELETE: begin
              if (link_live(sfirst)) begin
                mr_en      = 1'b1;
                mr_addr    = link_addr(sfirst);
                cur_next   = sfirst;
                kcnt_next  = '0;
                state_next = ST_WALK;
              end else begin
                wr_used  = 1'b1;
                wr_first = 1'b1;
                wr_last  = 1'b1;
                emit     = 1'b1;
              end
            end
            default: begin
              emit     = 1'b1;
              e_status = 1'b1;
            end
          endcase
        end
      end
      ST_LINK: begin
        if (out_free) begin
          // append caller at the tail
          if (link_live(slast)) begin
            mw_en   = 1'b1;
            mw_addr = link_addr(slast);
            mw_data = pid_to_link(wpid);
          end else begin
            wr_first  = 1'b1;
            first_val = pid_to_link(wpid);
          end
          wr_last    = 1'b1;
          last_val   = pid_to_link(wpid);
          emit       = 1'b1;
          e_blk      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          // dequeue head, rdata holds its successor
          emit     = 1'b1;
          e_wv     = 1'b1;
          e_wp     = link_to_pid(sfirst);
          wr_first = 1'b1;
          if (link_live(rdata)) begin
            first_val = rdata;
          end else begin
            wr_last = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          // release one waiter per cycle while the response register is free
          emit   = 1'b1;
          e_wv   = 1'b1;
          e_wp   = link_to_pid(cur);
          e_last = !link_live(rdata) || (kcnt == CNT_W'(MAX_RESULTS - 1));
          if (e_last) begin
            wr_used    = 1'b1;
            wr_first   = 1'b1;
            wr_last    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cur_next  = rdata;
            kcnt_next = kcnt + 1'b1;
            mr_en     = 1'b1;
            mr_addr   = link_addr(rdata);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ld_work) begin
      wslot <= cmd.slot;
      wpid  <= cmd.pid;
    end
    cur  <= cur_next;
    kcnt <= kcnt_next;
  end

  // slot table control fields
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        qfirst[i] <= EMPTY_LINK;
        qlast[i]  <= EMPTY_LINK;
      end
    end else begin
      if (wr_used) begin
        used[tbl_idx] <= used_val;
      end
      if (wr_first) begin
        qfirst[tbl_idx] <= first_val;
      end
      if (wr_last) begin
        qlast[tbl_idx] <= last_val;
      end
    end
  end

  // slot counts
  always_ff @(posedge clk) begin
    if (wr_level) begin
      level[tbl_idx] <= level_val;
    end
  end

  // waiter link memory, registered read
  always_ff @(posedge clk) begin
    if (mw_en) begin
      next_waiter[mw_addr] <= mw_data;
    end
    if (mr_en) begin
      rdata <= next_waiter[mr_addr];
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= e_status;
      created_id  <= e_cid;
      must_block  <= e_blk;
      woken_valid <= e_wv;
      woken_pid   <= e_wp;
      last        <= e_last;
    end
  end

endmodule

// ----- design/counting_semaphore_table.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_table: table of counting semaphores with FIFO wait lists
// Front end classifies requests, a short command queue decouples it from the
// back end, which owns the slot table and waiter links.
// ----------------------------------------------------------------------------
// The block serves one request at a time in its back end. A wait that
// queues the caller and a signal that wakes a waiter go through a second
// state (ST_LINK or ST_POP): the waiter link memory, with one write port
// and a registered read, needs a write or a read before the list can be
// relinked. Delete walks the link memory in ST_WALK, one result per released
// waiter (at most 64). Front end and command queue each register the command;
// the queue keeps taking requests until both its entries are full while the
// back end works or a response waits to be taken. There is no clearing pass
// after reset; link entries are only read once written.
module counting_semaphore_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [csem_pkg::MODE_W-1:0]   mode,
  input  logic [csem_pkg::ID_W-1:0]     sem_id,
  input  logic [csem_pkg::PID_W-1:0]    pid,
  input  logic signed [csem_pkg::COUNT_W-1:0] initial_count,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          status,
  output logic [csem_pkg::CID_W-1:0]    created_id,
  output logic                          must_block,
  output logic                          woken_valid,
  output logic [csem_pkg::PID_W-1:0]    woken_pid,
  output logic                          last
);
  import csem_pkg::*;

  logic cf_valid, cf_ready;
  cmd_t cf_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // intake and classification
  csem_front u_front (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .mode          (mode),
    .sem_id        (sem_id),
    .pid           (pid),
    .initial_count (initial_count),
    .cmd_valid     (cf_valid),
    .cmd_ready     (cf_ready),
    .cmd           (cf_cmd)
  );

  // decoupling queue
  csem_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cf_valid),
    .push_ready (cf_ready),
    .push_cmd   (cf_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  // execution
  csem_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (qb_valid),
    .cmd_ready   (qb_ready),
    .cmd         (qb_cmd),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .created_id  (created_id),
    .must_block  (must_block),
    .woken_valid (woken_valid),
    .woken_pid   (woken_pid),
    .last        (last)
  );

endmodule

// ----- design/csem_check.sv -----
// ----------------------------------------------------------------------------
// csem_check: port-level checks for the counting semaphore table
// Watches the response channel for stable stalls and for result field
// combinations that the semaphore logic must never produce.
// ----------------------------------------------------------------------------
module csem_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          status,
  input logic [csem_pkg::CID_W-1:0]    created_id,
  input logic                          must_block,
  input logic                          woken_valid,
  input logic [csem_pkg::PID_W-1:0]    woken_pid,
  input logic                          last
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(woken_pid) && $stable(last)
      && $stable(status))
    else $error("response changed while stalled");

  // an error ends the item and wakes nobody
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> last && !woken_valid && !must_block)
    else $error("error result not a lone final result");

  // a blocking wait is a single successful result
  a_block_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && must_block |-> last && !woken_valid && !status
      && (created_id == '0))
    else $error("blocking result carries other fields");

  // a non-final result only comes from a delete releasing waiters
  a_nonlast_wake: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !last |-> woken_valid && !status)
    else $error("non-final result without a released waiter");

endmodule

bind counting_semaphore_table csem_check u_csem_check (.*);
